@@ src/lpmr_pkg.sv @@
package lpmr_pkg;

    localparam int DEPTH         = 1024;
    localparam int WORD_BITS     = 32;
    localparam int MAX_MSG_WORDS = 64;

    localparam int PTR_BITS  = $clog2(DEPTH);
    localparam int CNT_BITS  = $clog2(DEPTH + 1);
    localparam int SIZE_BITS = 7;
    localparam int CFG_BITS  = 11;
    localparam int RW_RESET  = (1024 > DEPTH) ? DEPTH : 1024;

    localparam int QDEPTH    = 2;
    localparam int QPTR_BITS = $clog2(QDEPTH);
    localparam int QCNT_BITS = $clog2(QDEPTH + 1);

    typedef enum logic [1:0] {
        CMD_HDR  = 2'd0,
        CMD_DATA = 2'd1,
        CMD_DEQ  = 2'd2,
        CMD_BAD  = 2'd3
    } cmd_t;

    typedef enum logic [2:0] {
        ST_OK        = 3'd0,
        ST_FULL      = 3'd1,
        ST_EMPTY     = 3'd2,
        ST_TOO_SMALL = 3'd3,
        ST_SEQ_ERR   = 3'd4
    } status_t;

    typedef enum logic [1:0] {
        BK_IDLE,
        BK_HDR,
        BK_STREAM
    } back_state_t;

    // one job handed from front to back
    typedef struct packed {
        logic                 is_deq;
        status_t              status;
        logic [SIZE_BITS-1:0] length;
        logic [SIZE_BITS-1:0] cap;
        logic [PTR_BITS-1:0]  head;
    } entry_t;

    // dequeue completion reported back to the front
    typedef struct packed {
        logic                 valid;
        logic [PTR_BITS-1:0]  head;
        logic [SIZE_BITS-1:0] consumed;
    } done_t;

    function automatic logic [PTR_BITS-1:0] ptr_adv(input logic [PTR_BITS-1:0] p,
                                                    input logic [CNT_BITS-1:0] rw);
        logic [CNT_BITS-1:0] n;
        n = CNT_BITS'(p) + CNT_BITS'(1);
        return (n >= rw) ? '0 : n[PTR_BITS-1:0];
    endfunction

endpackage

@@ src/lpmr_ram.sv @@
module lpmr_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 1024
) (
    input  logic                     aclk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic                     re,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    always_ff @(posedge aclk) begin
        if (we) begin
            mem[waddr] <= wdata;
        end
        if (re) begin
            rdata_reg <= mem[raddr];
        end
    end

    assign rdata = rdata_reg;

endmodule

@@ src/lpmr_queue.sv @@
module lpmr_queue (
    input  logic             aclk,
    input  logic             aresetn,
    input  logic             push,
    input  lpmr_pkg::entry_t push_entry,
    output logic             full,
    input  logic             pop,
    output logic             valid,
    output lpmr_pkg::entry_t head_entry
);

    lpmr_pkg::entry_t                 slot_reg [lpmr_pkg::QDEPTH];
    logic [lpmr_pkg::QPTR_BITS-1:0]   wr_ptr_reg, rd_ptr_reg;
    logic [lpmr_pkg::QCNT_BITS-1:0]   count_reg;

    function automatic logic [lpmr_pkg::QPTR_BITS-1:0] qadv(
        input logic [lpmr_pkg::QPTR_BITS-1:0] p);
        return (int'(p) == lpmr_pkg::QDEPTH - 1) ? '0 : p + 1'b1;
    endfunction

    assign full       = (int'(count_reg) == lpmr_pkg::QDEPTH);
    assign valid      = (count_reg != '0);
    assign head_entry = slot_reg[rd_ptr_reg];

    always_ff @(posedge aclk) begin
        if (push) begin
            slot_reg[wr_ptr_reg] <= push_entry;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end else begin
            if (push) begin
                wr_ptr_reg <= qadv(wr_ptr_reg);
            end
            if (pop) begin
                rd_ptr_reg <= qadv(rd_ptr_reg);
            end
            if (push && !pop) begin
                count_reg <= count_reg + 1'b1;
            end else if (pop && !push) begin
                count_reg <= count_reg - 1'b1;
            end
        end
    end

endmodule

@@ src/lpmr_front.sv @@
module lpmr_front (
    input  logic                               aclk,
    input  logic                               aresetn,
    input  logic                               s_valid,
    output logic                               s_ready,
    input  logic [1:0]                         s_cmd,
    input  logic [lpmr_pkg::SIZE_BITS-1:0]     s_size,
    input  logic [31:0]                        s_data,
    input  logic                               cfg_we,
    input  logic [2:0]                         cfg_addr,
    input  logic [31:0]                        cfg_wdata,
    output logic [31:0]                        cfg_rdata,
    output logic                               q_push,
    output lpmr_pkg::entry_t                   q_entry,
    input  logic                               q_full,
    input  lpmr_pkg::done_t                    done,
    output logic [lpmr_pkg::CNT_BITS-1:0]      ring_words,
    output logic                               ram_we,
    output logic [lpmr_pkg::PTR_BITS-1:0]      ram_waddr,
    output logic [lpmr_pkg::WORD_BITS-1:0]     ram_wdata
);

    logic [lpmr_pkg::CNT_BITS-1:0]  ring_words_reg, ring_words_next;
    logic [lpmr_pkg::PTR_BITS-1:0]  head_reg, head_next;
    logic [lpmr_pkg::PTR_BITS-1:0]  tail_reg, tail_next;
    logic [lpmr_pkg::CNT_BITS-1:0]  occ_reg, occ_next;
    logic [lpmr_pkg::SIZE_BITS-1:0] pend_reg, pend_next;
    logic                           drop_reg, drop_next;
    logic                           wait_reg, wait_next;

    logic                          accept;
    logic [lpmr_pkg::CNT_BITS-1:0] free_words;
    logic [lpmr_pkg::CFG_BITS-1:0] cfg_val;

    assign s_ready    = !wait_reg && !q_full;
    assign accept     = s_valid && s_ready;
    assign ring_words = ring_words_reg;
    assign free_words = ring_words_reg - occ_reg;
    assign cfg_val    = cfg_wdata[lpmr_pkg::CFG_BITS-1:0];
    assign cfg_rdata  = cfg_addr[2] ? 32'd0 : 32'(ring_words_reg);

    always_comb begin
        ring_words_next = ring_words_reg;
        head_next       = head_reg;
        tail_next       = tail_reg;
        occ_next        = occ_reg;
        pend_next       = pend_reg;
        drop_next       = drop_reg;
        wait_next       = wait_reg;
        q_push          = accept;
        q_entry.is_deq  = 1'b0;
        q_entry.status  = lpmr_pkg::ST_SEQ_ERR;
        q_entry.length  = '0;
        q_entry.cap     = s_size;
        q_entry.head    = head_reg;
        ram_we          = 1'b0;
        ram_waddr       = tail_reg;
        ram_wdata       = lpmr_pkg::WORD_BITS'(s_size);

        if (accept) begin
            case (lpmr_pkg::cmd_t'(s_cmd))
                lpmr_pkg::CMD_HDR: begin
                    q_entry.length = s_size;
                    if (pend_reg != '0) begin
                        q_entry.status = lpmr_pkg::ST_SEQ_ERR;
                    end else if (int'(s_size) > lpmr_pkg::MAX_MSG_WORDS ||
                                 int'(s_size) + 1 > int'(free_words)) begin
                        q_entry.status = lpmr_pkg::ST_FULL;
                        pend_next      = s_size;
                        drop_next      = (s_size != '0);
                    end else begin
                        q_entry.status = lpmr_pkg::ST_OK;
                        ram_we         = 1'b1;
                        tail_next      = lpmr_pkg::ptr_adv(tail_reg, ring_words_reg);
                        occ_next       = occ_reg + lpmr_pkg::CNT_BITS'(s_size)
                                         + lpmr_pkg::CNT_BITS'(1);
                        pend_next      = s_size;
                        drop_next      = 1'b0;
                    end
                end
                lpmr_pkg::CMD_DATA: begin
                    if (pend_reg == '0) begin
                        q_entry.status = lpmr_pkg::ST_SEQ_ERR;
                    end else begin
                        pend_next = pend_reg - 1'b1;
                        if (drop_reg) begin
                            q_entry.status = lpmr_pkg::ST_FULL;
                            if (pend_reg == lpmr_pkg::SIZE_BITS'(1)) begin
                                drop_next = 1'b0;
                            end
                        end else begin
                            q_entry.status = lpmr_pkg::ST_OK;
                            ram_we         = 1'b1;
                            ram_wdata      = lpmr_pkg::WORD_BITS'(s_data);
                            tail_next      = lpmr_pkg::ptr_adv(tail_reg, ring_words_reg);
                        end
                    end
                end
                lpmr_pkg::CMD_DEQ: begin
                    if (pend_reg != '0) begin
                        q_entry.status = lpmr_pkg::ST_SEQ_ERR;
                    end else if (occ_reg == '0) begin
                        q_entry.status = lpmr_pkg::ST_EMPTY;
                    end else begin
                        q_entry.is_deq = 1'b1;
                        wait_next      = 1'b1;
                    end
                end
                default: begin
                    q_entry.status = lpmr_pkg::ST_SEQ_ERR;
                end
            endcase
        end

        // release after the back reports the dequeue done; a too-small answer frees nothing
        if (done.valid) begin
            head_next = done.head;
            occ_next  = (occ_reg >= lpmr_pkg::CNT_BITS'(done.consumed))
                        ? occ_reg - lpmr_pkg::CNT_BITS'(done.consumed) : '0;
            wait_next = 1'b0;
        end

        if (cfg_we && !cfg_addr[2]) begin
            if (int'(cfg_val) < 2) begin
                ring_words_next = lpmr_pkg::CNT_BITS'(2);
            end else if (int'(cfg_val) > lpmr_pkg::DEPTH) begin
                ring_words_next = lpmr_pkg::CNT_BITS'(lpmr_pkg::DEPTH);
            end else begin
                ring_words_next = lpmr_pkg::CNT_BITS'(cfg_val);
            end
            head_next = '0;
            tail_next = '0;
            occ_next  = '0;
            pend_next = '0;
            drop_next = 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            ring_words_reg <= lpmr_pkg::CNT_BITS'(lpmr_pkg::RW_RESET);
            head_reg       <= '0;
            tail_reg       <= '0;
            occ_reg        <= '0;
            pend_reg       <= '0;
            drop_reg       <= 1'b0;
            wait_reg       <= 1'b0;
        end else begin
            ring_words_reg <= ring_words_next;
            head_reg       <= head_next;
            tail_reg       <= tail_next;
            occ_reg        <= occ_next;
            pend_reg       <= pend_next;
            drop_reg       <= drop_next;
            wait_reg       <= wait_next;
        end
    end

endmodule

@@ src/lpmr_back.sv @@
module lpmr_back (
    input  logic                           aclk,
    input  logic                           aresetn,
    input  logic                           q_valid,
    input  lpmr_pkg::entry_t               q_entry,
    output logic                           q_pop,
    output lpmr_pkg::done_t                done,
    input  logic [lpmr_pkg::CNT_BITS-1:0]  ring_words,
    output logic                           ram_re,
    output logic [lpmr_pkg::PTR_BITS-1:0]  ram_raddr,
    input  logic [lpmr_pkg::WORD_BITS-1:0] ram_rdata,
    output logic                           m_valid,
    input  logic                           m_ready,
    output logic [2:0]                     m_status,
    output logic [lpmr_pkg::SIZE_BITS-1:0] m_length,
    output logic [31:0]                    m_data,
    output logic                           m_last
);

    lpmr_pkg::back_state_t          state_reg, state_next;
    logic [lpmr_pkg::SIZE_BITS-1:0] cap_reg, cap_next;
    logic [lpmr_pkg::PTR_BITS-1:0]  head_reg, head_next;
    logic [lpmr_pkg::SIZE_BITS-1:0] len_reg, len_next;
    logic [lpmr_pkg::PTR_BITS-1:0]  rd_ptr_reg, rd_ptr_next;
    logic [lpmr_pkg::SIZE_BITS-1:0] rd_left_reg, rd_left_next;
    logic [lpmr_pkg::SIZE_BITS-1:0] out_left_reg, out_left_next;
    logic                           pend_reg, pend_next;

    logic                           out_valid_reg, out_valid_next;
    lpmr_pkg::status_t              out_status_reg, out_status_next;
    logic [lpmr_pkg::SIZE_BITS-1:0] out_len_reg, out_len_next;
    logic [31:0]                    out_data_reg, out_data_next;
    logic                           out_last_reg, out_last_next;

    logic                           can_take;
    logic                           issue, load;
    logic [lpmr_pkg::SIZE_BITS-1:0] hdr_len;

    assign can_take = !out_valid_reg || m_ready;
    assign hdr_len  = (int'(ram_rdata[lpmr_pkg::SIZE_BITS-1:0]) > lpmr_pkg::MAX_MSG_WORDS)
                      ? lpmr_pkg::SIZE_BITS'(lpmr_pkg::MAX_MSG_WORDS)
                      : ram_rdata[lpmr_pkg::SIZE_BITS-1:0];

    assign m_valid  = out_valid_reg;
    assign m_status = out_status_reg;
    assign m_length = out_len_reg;
    assign m_data   = out_data_reg;
    assign m_last   = out_last_reg;

    always_comb begin
        state_next      = state_reg;
        cap_next        = cap_reg;
        head_next       = head_reg;
        len_next        = len_reg;
        rd_ptr_next     = rd_ptr_reg;
        rd_left_next    = rd_left_reg;
        out_left_next   = out_left_reg;
        pend_next       = pend_reg;
        out_valid_next  = out_valid_reg && !m_ready;
        out_status_next = out_status_reg;
        out_len_next    = out_len_reg;
        out_data_next   = out_data_reg;
        out_last_next   = out_last_reg;
        q_pop           = 1'b0;
        ram_re          = 1'b0;
        ram_raddr       = rd_ptr_reg;
        done            = '0;
        issue           = 1'b0;
        load            = 1'b0;

        case (state_reg)
            lpmr_pkg::BK_IDLE: begin
                if (q_valid) begin
                    if (q_entry.is_deq) begin
                        q_pop      = 1'b1;
                        ram_re     = 1'b1;
                        ram_raddr  = q_entry.head;
                        head_next  = q_entry.head;
                        cap_next   = q_entry.cap;
                        state_next = lpmr_pkg::BK_HDR;
                    end else if (can_take) begin
                        q_pop           = 1'b1;
                        out_valid_next  = 1'b1;
                        out_status_next = q_entry.status;
                        out_len_next    = q_entry.length;
                        out_data_next   = '0;
                        out_last_next   = 1'b1;
                    end
                end
            end
            lpmr_pkg::BK_HDR: begin
                if (hdr_len > cap_reg) begin
                    if (can_take) begin
                        out_valid_next  = 1'b1;
                        out_status_next = lpmr_pkg::ST_TOO_SMALL;
                        out_len_next    = hdr_len;
                        out_data_next   = '0;
                        out_last_next   = 1'b1;
                        done.valid      = 1'b1;
                        done.head       = head_reg;
                        done.consumed   = '0;
                        state_next      = lpmr_pkg::BK_IDLE;
                    end
                end else if (hdr_len == '0) begin
                    if (can_take) begin
                        out_valid_next  = 1'b1;
                        out_status_next = lpmr_pkg::ST_OK;
                        out_len_next    = '0;
                        out_data_next   = '0;
                        out_last_next   = 1'b1;
                        done.valid      = 1'b1;
                        done.head       = lpmr_pkg::ptr_adv(head_reg, ring_words);
                        done.consumed   = lpmr_pkg::SIZE_BITS'(1);
                        state_next      = lpmr_pkg::BK_IDLE;
                    end
                end else begin
                    len_next      = hdr_len;
                    rd_ptr_next   = lpmr_pkg::ptr_adv(head_reg, ring_words);
                    rd_left_next  = hdr_len;
                    out_left_next = hdr_len;
                    pend_next     = 1'b0;
                    state_next    = lpmr_pkg::BK_STREAM;
                end
            end
            lpmr_pkg::BK_STREAM: begin
                // read one word ahead; hold the read data while the output stalls
                issue = (rd_left_reg != '0) && (!pend_reg || can_take);
                load  = pend_reg && can_take;
                if (load) begin
                    out_valid_next  = 1'b1;
                    out_status_next = lpmr_pkg::ST_OK;
                    out_len_next    = len_reg;
                    out_data_next   = 32'(ram_rdata);
                    out_last_next   = (out_left_reg == lpmr_pkg::SIZE_BITS'(1));
                    out_left_next   = out_left_reg - 1'b1;
                    if (out_left_reg == lpmr_pkg::SIZE_BITS'(1)) begin
                        done.valid    = 1'b1;
                        done.head     = rd_ptr_reg;
                        done.consumed = len_reg + 1'b1;
                        state_next    = lpmr_pkg::BK_IDLE;
                    end
                end
                if (issue) begin
                    ram_re       = 1'b1;
                    ram_raddr    = rd_ptr_reg;
                    rd_ptr_next  = lpmr_pkg::ptr_adv(rd_ptr_reg, ring_words);
                    rd_left_next = rd_left_reg - 1'b1;
                    pend_next    = 1'b1;
                end else if (load) begin
                    pend_next = 1'b0;
                end
            end
            default: begin
                state_next = lpmr_pkg::BK_IDLE;
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg     <= lpmr_pkg::BK_IDLE;
            pend_reg      <= 1'b0;
            out_valid_reg <= 1'b0;
        end else begin
            state_reg     <= state_next;
            pend_reg      <= pend_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge aclk) begin
        cap_reg        <= cap_next;
        head_reg       <= head_next;
        len_reg        <= len_next;
        rd_ptr_reg     <= rd_ptr_next;
        rd_left_reg    <= rd_left_next;
        out_left_reg   <= out_left_next;
        out_status_reg <= out_status_next;
        out_len_reg    <= out_len_next;
        out_data_reg   <= out_data_next;
        out_last_reg   <= out_last_next;
    end

endmodule

@@ src/length_prefixed_message_ring.sv @@
// Channel | Direction | Handshake          | Contents
// s_      | in        | s_tvalid/s_tready  | s_tuser: cmd; s_tdata: size_words, data_in
// m_      | out       | m_tvalid/m_tready  | m_tdata: status, out_length, data_out; m_tlast
// APB     | in/out    | psel/penable       | register 0 (ring_words) at byte address 0
//
// Enqueue words are taken back to back while the two-entry job queue has room.
// A dequeue holds the input until answered: header read, header check, first payload
// read, then one word per cycle through the store's single registered read port
// while m_tready does not stall; a zero-length or too-small answer ends at the check.
// The front holds off new words until the back reports the dequeue done.
// Reset clears the front and job-queue pointers; the ring store itself is not cleared.
// A stalled m_tready holds the output register; the read pipeline stops once it holds
// one word read ahead.
module length_prefixed_message_ring (
    input  logic        aclk,
    input  logic        aresetn,

    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [39:0] s_tdata,   // [6:0] size_words, [38:7] data_in, [39] pad
    input  logic [1:0]  s_tuser,   // [1:0] cmd

    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [47:0] m_tdata,   // [2:0] status, [9:3] out_length, [41:10] data_out,
                                   // [47:42] zero
    output logic        m_tlast,   // last result word of the input word

    input  logic        psel,
    input  logic        penable,
    input  logic        pwrite,
    input  logic [2:0]  paddr,
    input  logic [31:0] pwdata,
    output logic [31:0] prdata,
    output logic        pready
);

    lpmr_pkg::entry_t                 push_entry, head_entry;
    lpmr_pkg::done_t                  done;
    logic                             q_push, q_full, q_pop, q_valid;
    logic [lpmr_pkg::CNT_BITS-1:0]    ring_words;
    logic                             ram_we, ram_re;
    logic [lpmr_pkg::PTR_BITS-1:0]    ram_waddr, ram_raddr;
    logic [lpmr_pkg::WORD_BITS-1:0]   ram_wdata, ram_rdata;
    logic                             cfg_we;
    logic [2:0]                       m_status;
    logic [lpmr_pkg::SIZE_BITS-1:0]   m_length;
    logic [31:0]                      m_data;

    // APB: no wait states, write lands on the access cycle
    assign pready = 1'b1;
    assign cfg_we = psel && penable && pwrite && pready;

    // front: classify words, own pointers, write the store
    lpmr_front u_front (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .s_valid    (s_tvalid),
        .s_ready    (s_tready),
        .s_cmd      (s_tuser),
        .s_size     (s_tdata[6:0]),
        .s_data     (s_tdata[38:7]),
        .cfg_we     (cfg_we),
        .cfg_addr   (paddr),
        .cfg_wdata  (pwdata),
        .cfg_rdata  (prdata),
        .q_push     (q_push),
        .q_entry    (push_entry),
        .q_full     (q_full),
        .done       (done),
        .ring_words (ring_words),
        .ram_we     (ram_we),
        .ram_waddr  (ram_waddr),
        .ram_wdata  (ram_wdata)
    );

    // decouple front and back
    lpmr_queue u_queue (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .push       (q_push),
        .push_entry (push_entry),
        .full       (q_full),
        .pop        (q_pop),
        .valid      (q_valid),
        .head_entry (head_entry)
    );

    lpmr_ram #(
        .WIDTH (lpmr_pkg::WORD_BITS),
        .DEPTH (lpmr_pkg::DEPTH)
    ) u_store (
        .aclk  (aclk),
        .we    (ram_we),
        .waddr (ram_waddr),
        .wdata (ram_wdata),
        .re    (ram_re),
        .raddr (ram_raddr),
        .rdata (ram_rdata)
    );

    // back: emit answers, stream dequeued messages
    lpmr_back u_back (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .q_valid    (q_valid),
        .q_entry    (head_entry),
        .q_pop      (q_pop),
        .done       (done),
        .ring_words (ring_words),
        .ram_re     (ram_re),
        .ram_raddr  (ram_raddr),
        .ram_rdata  (ram_rdata),
        .m_valid    (m_tvalid),
        .m_ready    (m_tready),
        .m_status   (m_status),
        .m_length   (m_length),
        .m_data     (m_data),
        .m_last     (m_tlast)
    );

    assign m_tdata = {6'd0, m_data, m_length, m_status};

endmodule
